// File: sv/ygb_pkg.sv
// ----------------------------------------------------------------------------
// ygb_pkg
// Types, constants and helper functions shared by the YCbCr glow blend core.
// ----------------------------------------------------------------------------
package ygb_pkg;

	// Configuration port
	localparam int CFG_AW = 1;
	localparam int CFG_DW = 8;
	localparam logic [CFG_AW-1:0] REG_BLEND_MODE = 1'd0;
	localparam logic [CFG_AW-1:0] REG_OPACITY    = 1'd1;

	localparam logic [2:0] BLEND_MODE_RST = 3'd3;
	localparam logic [7:0] OPACITY_RST    = 8'd25;

	// Blend modes; codes 6 and 7 fall back to simple
	typedef enum logic [2:0] {
		MODE_SIMPLE   = 3'd0,
		MODE_EXCL     = 3'd1,
		MODE_ADD      = 3'd2,
		MODE_UNFREEZE = 3'd3,
		MODE_DARKEN   = 3'd4,
		MODE_LIGHTEN  = 3'd5
	} mode_t;

	// Video range limits
	localparam logic [7:0] RANGE_LO        = 8'd16;
	localparam logic [7:0] RANGE_HI_WIDE   = 8'd240;
	localparam logic [7:0] RANGE_HI_NARROW = 8'd235;
	localparam logic [7:0] FULL_SCALE      = 8'd255;
	localparam logic [7:0] DEN_MIN         = 8'd16;
	// quotient at which 255 - q reaches the lower range limit
	localparam logic [15:0] UNF_SAT_Q      = 16'd239;

	// Channel payloads
	typedef struct packed {
		logic [7:0] orig_y;
		logic [7:0] orig_cb;
		logic [7:0] orig_cr;
		logic [7:0] blur_y;
		logic [7:0] blur_cb;
		logic [7:0] blur_cr;
	} pix_in_t;

	typedef struct packed {
		logic [7:0] out_y;
		logic [7:0] out_cb;
		logic [7:0] out_cr;
	} pix_out_t;

	// Stage 1: raw pixel plus all first-level products
	typedef struct packed {
		logic [2:0]         mode;
		logic               hit;
		pix_in_t            pix;
		logic [15:0]        p_oy;
		logic [15:0]        p_by;
		logic [15:0]        p_ocb;
		logic [15:0]        p_bcb;
		logic [15:0]        p_ocr;
		logic [15:0]        p_bcr;
		logic [15:0]        p_sim;
		logic [15:0]        p_o2k;
		logic signed [15:0] cp_cb;
		logic signed [15:0] cp_cr;
	} st1_t;

	// Stage 2: preselected result, exclusive luma still pending
	typedef struct packed {
		logic [2:0]  mode;
		logic [7:0]  ya;
		logic [7:0]  yb;
		logic [15:0] ey_prod;
		pix_out_t    res;
	} st2_t;

	// Stage 3..5: final result for all modes but unfreeze
	typedef struct packed {
		logic     unf;
		pix_out_t res;
	} st3_t;

	// Restoring divider state
	typedef struct packed {
		logic [15:0] num;
		logic [7:0]  den;
		logic [7:0]  rem;
		logic [15:0] quo;
	} div_t;

	// Four quotient bits of restoring division
	function automatic div_t div_step4(div_t x);
		div_t       y;
		logic [8:0] t;
		int         i;
		y = x;
		for (i = 0; i < 4; i++) begin
			t = {y.rem, y.num[15]};
			y.num = {y.num[14:0], 1'b0};
			if (t >= {1'b0, y.den}) begin
				y.rem = 8'(t - {1'b0, y.den});
				y.quo = {y.quo[14:0], 1'b1};
			end else begin
				y.rem = t[7:0];
				y.quo = {y.quo[14:0], 1'b0};
			end
		end
		return y;
	endfunction

	// Clamp a small signed value into [lo, hi]
	function automatic logic [7:0] clamp12(logic signed [11:0] v, logic [7:0] lo,
			logic [7:0] hi);
		logic [7:0] r;
		if (v < $signed({4'b0, lo})) begin
			r = lo;
		end else if (v > $signed({4'b0, hi})) begin
			r = hi;
		end else begin
			r = v[7:0];
		end
		return r;
	endfunction

	// Unfreeze tail: clamp(255 - q, 16, hi)
	function automatic logic [7:0] unf_clamp(logic [15:0] q, logic [7:0] hi);
		logic [7:0] v;
		logic [7:0] r;
		v = 8'(FULL_SCALE - q[7:0]);
		if (q >= UNF_SAT_Q) begin
			r = RANGE_LO;
		end else if (v > hi) begin
			r = hi;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

// File: sv/ygb_div.sv
// ----------------------------------------------------------------------------
// ygb_div
// Pipelined 16 by 8 bit restoring divider, four quotient bits per stage.
// ----------------------------------------------------------------------------
module ygb_div
	import ygb_pkg::*;
(
	input  logic        clk,
	input  logic [4:0]  en,
	input  logic [15:0] num,
	input  logic [7:0]  den,
	output logic [15:0] quo
);

	div_t dv_s1, dv_s2, dv_s3, dv_s4, dv_s5;
	div_t ld_s1;

	always_comb begin
		ld_s1.num = num;
		ld_s1.den = den;
		ld_s1.rem = '0;
		ld_s1.quo = '0;
	end

	// load, then four steps of four bits
	always_ff @(posedge clk) begin
		if (en[0]) dv_s1 <= ld_s1;
		if (en[1]) dv_s2 <= div_step4(dv_s1);
		if (en[2]) dv_s3 <= div_step4(dv_s2);
		if (en[3]) dv_s4 <= div_step4(dv_s3);
		if (en[4]) dv_s5 <= div_step4(dv_s4);
	end

	assign quo = dv_s5.quo;

endmodule

// File: sv/ycbcr_glow_blend_modes_core.sv
// ----------------------------------------------------------------------------
// ycbcr_glow_blend_modes_core
// Blends an original YCbCr pixel with its blurred counterpart under the
// configured mode and opacity.
// ----------------------------------------------------------------------------
// Throughput: one pixel per clock while mix_stall is low; six register stages,
//   the depth set by the unfreeze divider. Stages hold on stall and fill
//   bubbles.
// Reset: all valid bits clear, blend_mode = 3, opacity = 25.
module ycbcr_glow_blend_modes_core
	import ygb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pix_valid,
	output logic              pix_stall,
	input  pix_in_t           pix,
	output logic              mix_valid,
	input  logic              mix_stall,
	output pix_out_t          mix,
	input  logic              cfg_we,
	input  logic [CFG_AW-1:0] cfg_addr,
	input  logic [CFG_DW-1:0] cfg_wdata
);

	logic [2:0] blend_mode_q;
	logic [7:0] opacity_q;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	logic en1, en2, en3, en4, en5, en6;

	st1_t     data_s1;
	st2_t     data_s2;
	st3_t     data_s3, data_s4, data_s5;
	pix_out_t data_s6;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blend_mode_q <= BLEND_MODE_RST;
			opacity_q    <= OPACITY_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_BLEND_MODE: blend_mode_q <= cfg_wdata[2:0];
				REG_OPACITY:    opacity_q    <= cfg_wdata;
				default:        ;
			endcase
		end
	end

	// Stage enables: a stage loads when empty or when its successor moves
	assign en6 = !valid_s6 || !mix_stall;
	assign en5 = !valid_s5 || en6;
	assign en4 = !valid_s4 || en5;
	assign en3 = !valid_s3 || en4;
	assign en2 = !valid_s2 || en3;
	assign en1 = !valid_s1 || en2;
	assign pix_stall = !en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			if (en1) valid_s1 <= pix_valid;
			if (en2) valid_s2 <= valid_s1;
			if (en3) valid_s3 <= valid_s2;
			if (en4) valid_s4 <= valid_s3;
			if (en5) valid_s5 <= valid_s4;
			if (en6) valid_s6 <= valid_s5;
		end
	end

	// Stage A: first-level products, squares and divisors
	logic [7:0]        o1, o2, ty_abs, ncb, ncr;
	logic signed [7:0] ca_cb, cb_cb, ca_cr, cb_cr;
	logic [15:0]       sq_y, sq_cb, sq_cr;
	logic [7:0]        den_y, den_cb, den_cr;
	st1_t              nx_s1;

	always_comb begin
		o1     = opacity_q;
		o2     = ~opacity_q;
		ty_abs = (o1 >= pix.blur_y) ? 8'(o1 - pix.blur_y) : 8'(pix.blur_y - o1);
		ncb    = ~pix.blur_cb;
		ncr    = ~pix.blur_cr;
		sq_y   = ty_abs * ty_abs;
		sq_cb  = ncb * ncb;
		sq_cr  = ncr * ncr;
		den_y  = (pix.orig_y  < DEN_MIN) ? DEN_MIN : pix.orig_y;
		den_cb = (pix.orig_cb < DEN_MIN) ? DEN_MIN : pix.orig_cb;
		den_cr = (pix.orig_cr < DEN_MIN) ? DEN_MIN : pix.orig_cr;
		// chroma minus offset as signed values
		ca_cb  = $signed(pix.orig_cb ^ 8'h80);
		cb_cb  = $signed(pix.blur_cb ^ 8'h80);
		ca_cr  = $signed(pix.orig_cr ^ 8'h80);
		cb_cr  = $signed(pix.blur_cr ^ 8'h80);

		nx_s1.mode  = blend_mode_q;
		nx_s1.hit   = ((blend_mode_q == MODE_DARKEN)  && (pix.orig_y > pix.blur_y)) ||
		              ((blend_mode_q == MODE_LIGHTEN) && (pix.orig_y < pix.blur_y));
		nx_s1.pix   = pix;
		nx_s1.p_oy  = pix.orig_y  * o1;
		nx_s1.p_by  = pix.blur_y  * o2;
		nx_s1.p_ocb = pix.orig_cb * o1;
		nx_s1.p_bcb = pix.blur_cb * o2;
		nx_s1.p_ocr = pix.orig_cr * o1;
		nx_s1.p_bcr = pix.blur_cr * o2;
		nx_s1.p_sim = pix.blur_y  * o1;
		nx_s1.p_o2k = o2 * FULL_SCALE;
		nx_s1.cp_cb = ca_cb * cb_cb;
		nx_s1.cp_cr = ca_cr * cb_cr;
	end

	always_ff @(posedge clk) begin
		if (en1) data_s1 <= nx_s1;
	end

	// Unfreeze dividers, one per channel
	logic [15:0] quo_y, quo_cb, quo_cr;
	logic [4:0]  div_en;

	assign div_en = {en5, en4, en3, en2, en1};

	ygb_div u_div_y (
		.clk (clk), .en (div_en), .num (sq_y),  .den (den_y),  .quo (quo_y)
	);
	ygb_div u_div_cb (
		.clk (clk), .en (div_en), .num (sq_cb), .den (den_cb), .quo (quo_cb)
	);
	ygb_div u_div_cr (
		.clk (clk), .en (div_en), .num (sq_cr), .den (den_cr), .quo (quo_cr)
	);

	// Stage B: second products and per-mode results
	logic signed [11:0] ex_cb, ex_cr, ad_y, ad_cb, ad_cr;
	logic [15:0]        dl_y, dl_cb, dl_cr, sim_p;
	logic [7:0]         sim_y;
	st2_t               nx_s2;

	always_comb begin
		ex_cb = 12'($signed(data_s1.pix.orig_cb ^ 8'h80)) +
		        12'($signed(data_s1.pix.blur_cb ^ 8'h80)) -
		        12'(data_s1.cp_cb >>> 8) + 12'sd128;
		ex_cr = 12'($signed(data_s1.pix.orig_cr ^ 8'h80)) +
		        12'($signed(data_s1.pix.blur_cr ^ 8'h80)) -
		        12'(data_s1.cp_cr >>> 8) + 12'sd128;
		ad_y  = $signed(12'({3'b0, data_s1.p_oy[15:7]}) +
		        12'({2'b0, data_s1.p_by[15:7], 1'b0}) - 12'd255);
		ad_cb = $signed(12'({4'b0, data_s1.pix.orig_cb}) +
		        12'({3'b0, data_s1.pix.blur_cb, 1'b0}) - 12'd255);
		ad_cr = $signed(12'({4'b0, data_s1.pix.orig_cr}) +
		        12'({3'b0, data_s1.pix.blur_cr, 1'b0}) - 12'd255);
		dl_y  = data_s1.p_oy  + data_s1.p_by;
		dl_cb = data_s1.p_ocb + data_s1.p_bcb;
		dl_cr = data_s1.p_ocr + data_s1.p_bcr;
		sim_p = data_s1.p_sim + data_s1.p_o2k;
		sim_y = {1'b0, data_s1.pix.orig_y[7:1]} + {1'b0, sim_p[15:9]};

		nx_s2.mode    = data_s1.mode;
		nx_s2.ya      = data_s1.p_oy[15:8];
		nx_s2.yb      = data_s1.p_by[15:8];
		nx_s2.ey_prod = data_s1.p_oy[15:8] * data_s1.p_by[15:8];

		case (data_s1.mode)
			MODE_EXCL: begin
				nx_s2.res.out_y  = '0;
				nx_s2.res.out_cb = clamp12(ex_cb, RANGE_LO, RANGE_HI_NARROW);
				nx_s2.res.out_cr = clamp12(ex_cr, RANGE_LO, RANGE_HI_NARROW);
			end
			MODE_ADD: begin
				nx_s2.res.out_y  = clamp12(ad_y,  RANGE_LO, RANGE_HI_NARROW);
				nx_s2.res.out_cb = clamp12(ad_cb, RANGE_LO, RANGE_HI_WIDE);
				nx_s2.res.out_cr = clamp12(ad_cr, RANGE_LO, RANGE_HI_WIDE);
			end
			MODE_UNFREEZE: begin
				// replaced by the divider outputs at the last stage
				nx_s2.res = '0;
			end
			MODE_DARKEN, MODE_LIGHTEN: begin
				if (data_s1.hit) begin
					nx_s2.res.out_y  = dl_y[15:8];
					nx_s2.res.out_cb = dl_cb[15:8];
					nx_s2.res.out_cr = dl_cr[15:8];
				end else begin
					nx_s2.res.out_y  = data_s1.pix.orig_y;
					nx_s2.res.out_cb = data_s1.pix.orig_cb;
					nx_s2.res.out_cr = data_s1.pix.orig_cr;
				end
			end
			default: begin
				nx_s2.res.out_y  = sim_y;
				nx_s2.res.out_cb = data_s1.pix.orig_cb;
				nx_s2.res.out_cr = data_s1.pix.orig_cr;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en2) data_s2 <= nx_s2;
	end

	// Stage C: exclusive luma
	logic signed [11:0] ex_y;
	st3_t               nx_s3;

	always_comb begin
		ex_y = $signed(12'(data_s2.ya) + 12'(data_s2.yb) - 12'(data_s2.ey_prod[15:8]));
		nx_s3.unf = (data_s2.mode == MODE_UNFREEZE);
		nx_s3.res = data_s2.res;
		if (data_s2.mode == MODE_EXCL) begin
			nx_s3.res.out_y = clamp12(ex_y, RANGE_LO, RANGE_HI_WIDE);
		end
	end

	// Stages D, E carry the result alongside the divider
	always_ff @(posedge clk) begin
		if (en3) data_s3 <= nx_s3;
		if (en4) data_s4 <= data_s3;
		if (en5) data_s5 <= data_s4;
	end

	// Output stage: unfreeze tail or the carried result
	pix_out_t nx_s6;

	always_comb begin
		if (data_s5.unf) begin
			nx_s6.out_y  = unf_clamp(quo_y,  RANGE_HI_WIDE);
			nx_s6.out_cb = unf_clamp(quo_cb, RANGE_HI_NARROW);
			nx_s6.out_cr = unf_clamp(quo_cr, RANGE_HI_NARROW);
		end else begin
			nx_s6 = data_s5.res;
		end
	end

	always_ff @(posedge clk) begin
		if (en6) data_s6 <= nx_s6;
	end

	assign mix_valid = valid_s6;
	assign mix       = data_s6;

endmodule

// File: sv/ygb_checker.sv
// ----------------------------------------------------------------------------
// ygb_checker
// Port-level checks for the glow blend core, bound to the top level.
// ----------------------------------------------------------------------------
module ygb_checker
	import ygb_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     pix_stall,
	input logic     mix_valid,
	input logic     mix_stall,
	input pix_out_t mix
);

	// a held result stays offered
	a_mix_hold: assert property (@(posedge clk) disable iff (!arst_n)
		mix_valid && mix_stall |=> mix_valid)
		else $error("result dropped while stalled");

	// a held result keeps its value
	a_mix_stable: assert property (@(posedge clk) disable iff (!arst_n)
		mix_valid && mix_stall |=> $stable(mix))
		else $error("result changed while stalled");

	// with the output free the whole pipeline moves, so input is never stalled
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(!mix_valid || !mix_stall) |-> !pix_stall)
		else $error("input stalled while the output can move");

	// no result right out of reset
	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !mix_valid)
		else $error("result valid right after reset");

endmodule

bind ycbcr_glow_blend_modes_core ygb_checker u_ygb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.pix_stall (pix_stall),
	.mix_valid (mix_valid),
	.mix_stall (mix_stall),
	.mix       (mix)
);

// File: tb/ycbcr_glow_blend_modes_checker.sv
// ----------------------------------------------------------------------------
// ycbcr_glow_blend_modes_checker
// Watches the pixel, result and register ports of the glow blend core, keeps
// its own copy of the blend mode and opacity, predicts each blended pixel and
// compares every result transaction field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module ycbcr_glow_blend_modes_checker
	import ygb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pix_valid,
	input  logic              pix_stall,
	input  pix_in_t           pix,
	input  logic              mix_valid,
	input  logic              mix_stall,
	input  pix_out_t          mix,
	input  logic              cfg_we,
	input  logic [CFG_AW-1:0] cfg_addr,
	input  logic [CFG_DW-1:0] cfg_wdata,
	output int                fails,
	output int                pending,
	output int                checked
);

	// Shadow copy of the two registers
	logic [2:0] mode_q;
	logic [7:0] opac_q;

	// Blended pixels still owed by the core, oldest first
	pix_out_t blend_q[$];

	function automatic int clip(int v, int lo, int hi);
		if (v < lo) begin
			return lo;
		end
		if (v > hi) begin
			return hi;
		end
		return v;
	endfunction

	// Chroma is signed around 128; the product shift floors
	function automatic logic [7:0] excl_chroma(logic [7:0] o, logic [7:0] bl);
		int a;
		int b;
		a = int'(o) - 128;
		b = int'(bl) - 128;
		return 8'(clip(a + b - ((a * b) >>> 8) + 128, RANGE_LO, RANGE_HI_NARROW));
	endfunction

	// Denominator floored at 16, truncating divide
	function automatic logic [7:0] unfreeze_chan(logic [7:0] o, int base, logic [7:0] bl,
			int hi);
		int d;
		int t;
		d = (o < DEN_MIN) ? int'(DEN_MIN) : int'(o);
		t = base - int'(bl);
		return 8'(clip(255 - (t * t) / d, RANGE_LO, hi));
	endfunction

	function automatic pix_out_t blend_pixel(pix_in_t p, logic [2:0] mode, logic [7:0] opac);
		pix_out_t r;
		int       w1, w2, a, b;
		int       oy, ocb, ocr, by, bcb, bcr;
		oy  = int'(p.orig_y);
		ocb = int'(p.orig_cb);
		ocr = int'(p.orig_cr);
		by  = int'(p.blur_y);
		bcb = int'(p.blur_cb);
		bcr = int'(p.blur_cr);
		w1  = int'(opac);
		w2  = 255 - w1;
		r.out_y  = p.orig_y;
		r.out_cb = p.orig_cb;
		r.out_cr = p.orig_cr;
		case (mode)
			MODE_EXCL: begin
				a = (oy * w1) >> 8;
				b = (by * w2) >> 8;
				r.out_y  = 8'(clip(a + b - ((a * b) >> 8), RANGE_LO, RANGE_HI_WIDE));
				r.out_cb = excl_chroma(p.orig_cb, p.blur_cb);
				r.out_cr = excl_chroma(p.orig_cr, p.blur_cr);
			end
			MODE_ADD: begin
				a = (oy * w1) >> 7;
				b = (by * w2) >> 7;
				r.out_y  = 8'(clip(a + 2 * b - 255, RANGE_LO, RANGE_HI_NARROW));
				r.out_cb = 8'(clip(ocb + 2 * bcb - 255, RANGE_LO, RANGE_HI_WIDE));
				r.out_cr = 8'(clip(ocr + 2 * bcr - 255, RANGE_LO, RANGE_HI_WIDE));
			end
			MODE_UNFREEZE: begin
				r.out_y  = unfreeze_chan(p.orig_y, w1, p.blur_y, RANGE_HI_WIDE);
				r.out_cb = unfreeze_chan(p.orig_cb, 255, p.blur_cb, RANGE_HI_NARROW);
				r.out_cr = unfreeze_chan(p.orig_cr, 255, p.blur_cr, RANGE_HI_NARROW);
			end
			MODE_DARKEN, MODE_LIGHTEN: begin
				// pixel passes untouched unless the luma test holds
				if ((mode == MODE_DARKEN && oy > by) || (mode == MODE_LIGHTEN && oy < by)) begin
					r.out_y  = 8'((oy * w1 + by * w2) >> 8);
					r.out_cb = 8'((ocb * w1 + bcb * w2) >> 8);
					r.out_cr = 8'((ocr * w1 + bcr * w2) >> 8);
				end
			end
			default: begin
				// simple, also the two spare codes: luma only
				a = (by * w1 + w2 * 255) >> 8;
				r.out_y = 8'((oy >> 1) + (a >> 1));
			end
		endcase
		return r;
	endfunction

	task automatic report_field(string name, logic [7:0] want_v, logic [7:0] got_v);
		$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
		fails++;
	endtask

	// Predict on input transactions, compare on output transactions
	always @(posedge clk or negedge arst_n) begin
		pix_out_t want;
		if (!arst_n) begin
			mode_q = BLEND_MODE_RST;
			opac_q = OPACITY_RST;
			blend_q.delete();
			fails = 0;
			pending = 0;
			checked = 0;
		end else begin
			if (pix_valid && !pix_stall) begin
				blend_q.push_back(blend_pixel(pix, mode_q, opac_q));
			end
			if (mix_valid && !mix_stall) begin
				if (blend_q.size() == 0) begin
					$display("%0t ns: result with none expected, got %0d %0d %0d",
						$time, mix.out_y, mix.out_cb, mix.out_cr);
					fails++;
				end else begin
					want = blend_q.pop_front();
					checked++;
					if (mix.out_y !== want.out_y) begin
						report_field("out_y", want.out_y, mix.out_y);
					end
					if (mix.out_cb !== want.out_cb) begin
						report_field("out_cb", want.out_cb, mix.out_cb);
					end
					if (mix.out_cr !== want.out_cr) begin
						report_field("out_cr", want.out_cr, mix.out_cr);
					end
				end
			end
			// the bench must let register writes land only while the core is idle; nothing here checks it
			if (cfg_we) begin
				case (cfg_addr)
					REG_BLEND_MODE: mode_q = cfg_wdata[2:0];
					REG_OPACITY:    opac_q = cfg_wdata[7:0];
					default: ;
				endcase
			end
			pending = blend_q.size();
		end
	end

endmodule

// File: tb/ycbcr_glow_blend_modes_core_tb.sv
// ----------------------------------------------------------------------------
// ycbcr_glow_blend_modes_core_tb
// Drives the glow blend core with directed and random pixels under every
// mode code and a range of opacities, with random gaps and output stalls
// and one long output hold; the checker predicts and compares each result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module ycbcr_glow_blend_modes_core_tb;
	import ygb_pkg::*;

	localparam int LIMIT_CYCLES = 200000;
	localparam int HOLD_CYCLES  = 80;
	localparam int HOLD_AFTER   = 100;
	localparam int SETTLE       = 12;
	localparam int PHASES       = 10;
	localparam int PHASE_PIX    = 45;

	// Spare mode codes, decoded as simple
	localparam logic [2:0] MODE_SPARE_A = 3'd6;
	localparam logic [2:0] MODE_SPARE_B = 3'd7;

	logic              clk;
	logic              arst_n;
	logic              pix_valid;
	logic              pix_stall;
	pix_in_t           pix;
	logic              mix_valid;
	logic              mix_stall;
	pix_out_t          mix;
	logic              cfg_we;
	logic [CFG_AW-1:0] cfg_addr;
	logic [CFG_DW-1:0] cfg_wdata;

	int         fails;
	int         pending;
	int         checked;
	int         sent   = 0;
	int         n_cfg  = 0;
	int         cycles = 0;
	bit         calm_tx;
	bit         held;
	logic [2:0] mode_codes [8];

	ycbcr_glow_blend_modes_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pix       (pix),
		.mix_valid (mix_valid),
		.mix_stall (mix_stall),
		.mix       (mix),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	ycbcr_glow_blend_modes_checker chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pix       (pix),
		.mix_valid (mix_valid),
		.mix_stall (mix_stall),
		.mix       (mix),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.fails     (fails),
		.pending   (pending),
		.checked   (checked)
	);

	// 4 ns clock
	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("Timeout after %0d cycles, %0d results outstanding", cycles, pending);
			$display("Some tests failed");
			$finish;
		end
	end

	// Mostly zero, some short, a few long
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end
		if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 30);
	endfunction

	// Leans toward the range edges and the unfreeze floor
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 9))
			0: return 8'd0;
			1: return 8'd255;
			2: return 8'($urandom_range(0, 31));
			3: return 8'($urandom_range(224, 255));
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic pix_in_t pick_pix();
		pix_in_t p;
		p.orig_y  = pick_byte();
		p.orig_cb = pick_byte();
		p.orig_cr = pick_byte();
		p.blur_y  = pick_byte();
		p.blur_cb = pick_byte();
		p.blur_cr = pick_byte();
		return p;
	endfunction

	// One input transaction; entered and left on a falling edge
	task automatic send_pix(input pix_in_t p);
		int gap;
		gap = calm_tx ? 0 : idle_len();
		if (gap > 0) begin
			pix_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		pix       <= p;
		pix_valid <= 1'b1;
		@(posedge clk);
		while (pix_stall) begin
			@(posedge clk);
		end
		sent++;
		@(negedge clk);
	endtask

	// Stop offering and let the pipeline empty
	task automatic settle();
		pix_valid <= 1'b0;
		while (pending != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE) @(negedge clk);
	endtask

	// Mode write carries junk above bit 2, which the core must drop
	task automatic set_cfg(input logic [2:0] code, input logic [7:0] opac);
		cfg_we    <= 1'b1;
		cfg_addr  <= REG_BLEND_MODE;
		cfg_wdata <= {5'($urandom), code};
		@(negedge clk);
		cfg_addr  <= REG_OPACITY;
		cfg_wdata <= opac;
		@(negedge clk);
		cfg_we    <= 1'b0;
		n_cfg++;
	endtask

	// Output side: random stalls, calm stretches, one long hold
	initial begin
		int hold;
		int span;
		bit calm;
		mix_stall = 1'b0;
		hold = 0;
		span = 0;
		calm = 1'b0;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (span == 0) begin
				span = 50;
				calm = ($urandom_range(0, 2) == 0);
			end
			span--;
			if (!held && sent >= HOLD_AFTER) begin
				held = 1'b1;
				hold = HOLD_CYCLES;
			end
			if (hold > 0) begin
				hold--;
				mix_stall <= 1'b1;
			end else if (calm) begin
				mix_stall <= 1'b0;
			end else begin
				hold = idle_len();
				mix_stall <= (hold > 0);
				if (hold > 0) begin
					hold--;
				end
			end
		end
	end

	// Stimulus
	initial begin
		pix_in_t    dir_pix [3];
		logic [7:0] opac;
		int         i, j, offs;

		arst_n    = 1'b0;
		pix_valid = 1'b0;
		pix       = '0;
		cfg_we    = 1'b0;
		cfg_addr  = '0;
		cfg_wdata = '0;
		calm_tx   = 1'b0;
		mode_codes = '{MODE_SIMPLE, MODE_EXCL, MODE_ADD, MODE_UNFREEZE,
			MODE_DARKEN, MODE_LIGHTEN, MODE_SPARE_A, MODE_SPARE_B};

		// orig below blur, full chroma swing with negative products
		dir_pix[0] = '{8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255};
		// orig above blur
		dir_pix[1] = '{8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0};
		// equal luma, chroma on opposite sides of 128
		dir_pix[2] = '{8'd90, 8'd20, 8'd250, 8'd90, 8'd240, 8'd10};

		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset values: unfreeze at opacity 25
		calm_tx = 1'b1;
		send_pix(dir_pix[0]);
		send_pix(dir_pix[1]);

		// Directed: every mode code at an opacity extreme
		for (i = 0; i < 8; i++) begin
			settle();
			set_cfg(mode_codes[i], (i % 2 == 0) ? 8'd0 : 8'd255);
			calm_tx = (i % 2 == 0);
			for (j = 0; j < 3; j++) begin
				send_pix(dir_pix[j]);
			end
		end

		// Random phases, walking through all mode codes
		offs = $urandom_range(0, 7);
		for (i = 0; i < PHASES; i++) begin
			settle();
			case ($urandom_range(0, 4))
				0: opac = 8'd0;
				1: opac = 8'd255;
				2: opac = 8'd1;
				3: opac = 8'd254;
				default: opac = 8'($urandom_range(0, 255));
			endcase
			set_cfg(mode_codes[(i + offs) % 8], opac);
			calm_tx = ($urandom_range(0, 2) == 0);
			for (j = 0; j < PHASE_PIX; j++) begin
				send_pix(pick_pix());
			end
		end

		settle();
		$display("Covered %0d pixels over %0d register settings, all eight mode codes,",
			sent, n_cfg);
		$display("random gaps and stalls and a %0d-cycle output hold; %0d results compared.",
			HOLD_CYCLES, checked);
		if (fails == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
